@@ rtl/sstd_pkg.sv @@
// shared types, constants and the character font for the seven-segment text display
// no dependencies
package sstd_pkg;

  localparam int unsigned StoreDepth = 8;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned PosW       = 4;

  localparam logic [7:0] SegBlank = 8'hff;
  localparam logic [7:0] DotClear = 8'h7f;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharB     = 8'h42;
  localparam logic [7:0] CharC     = 8'h43;
  localparam logic [7:0] CharD     = 8'h44;
  localparam logic [7:0] CharE     = 8'h45;
  localparam logic [7:0] CharF     = 8'h46;
  localparam logic [7:0] CharH     = 8'h48;
  localparam logic [7:0] CharL     = 8'h4c;
  localparam logic [7:0] CharN     = 8'h4e;
  localparam logic [7:0] CharP     = 8'h50;
  localparam logic [7:0] CharU     = 8'h55;

  localparam logic [7:0] DigitFont [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  typedef enum logic {
    OpChar = 1'b0,
    OpTick = 1'b1
  } op_e;

  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [7:0] char_code;
    logic       start_of_text;
  } beat_t;

  // active-low font, bits 0..6 = segments a..g, bit 7 = dot
  function automatic logic [7:0] font_of(input logic [7:0] c);
    logic [7:0] diff;
    logic [7:0] seg;
    diff = c - CharZero;
    case (c) inside
      [CharZero:CharNine]: seg = DigitFont[diff[3:0]];
      CharSpace:           seg = SegBlank;
      CharDash:            seg = 8'hbf;
      CharA:               seg = 8'h88;
      CharB:               seg = 8'h83;
      CharC:               seg = 8'hc6;
      CharD:               seg = 8'ha1;
      CharE:               seg = 8'h86;
      CharF:               seg = 8'h8e;
      CharH:               seg = 8'h89;
      CharL:               seg = 8'hc7;
      CharN:               seg = 8'hc8;
      CharP:               seg = 8'h8c;
      CharU:               seg = 8'hc1;
      default:             seg = SegBlank;
    endcase
    return seg;
  endfunction

endpackage

@@ rtl/seven_segment_text_display.sv @@
// seven-segment text display controller, top level
// depends on sstd_pkg, sstd_in_reg, sstd_store, sstd_scan
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | op_i, char_code_i, start_of_text_i
//  out     | source    | out_valid_o/out_ready_i| segments_o, digit_enable_o, digit_index_o
//
// one beat per cycle in while in_ready_o is high; a beat is held in the input register,
// then a tick lands in the result register and raises out_valid_o.
// a character beat updates the digit store and gives no result.
// reset clears the store to blank, the write and scan positions and both valids.
// a stalled result holds a tick beat in the input register and every beat behind it;
// character beats pass freely while no tick waits there.
module seven_segment_text_display import sstd_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] char_code_i,
  input  logic       start_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] segments_o,
  output logic [7:0] digit_enable_o,
  output logic [2:0] digit_index_o
);

  beat_t           beat;
  logic            scan_ready;
  logic            advance;
  logic            wr_en;
  logic            tick;
  logic [IdxW-1:0] scan_idx;
  logic [7:0]      rd_data;

  assign advance = beat.valid && (beat.op == OpChar || scan_ready);
  assign wr_en   = beat.valid && beat.op == OpChar;
  assign tick    = beat.valid && beat.op == OpTick && scan_ready;

  sstd_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .char_code_i     (char_code_i),
    .start_of_text_i (start_of_text_i),
    .advance_i       (advance),
    .beat_o          (beat)
  );

  sstd_store #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_store (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (wr_en),
    .char_code_i     (beat.char_code),
    .start_of_text_i (beat.start_of_text),
    .rd_idx_i        (scan_idx),
    .rd_data_o       (rd_data)
  );

  sstd_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tick_i         (tick),
    .ready_o        (scan_ready),
    .scan_idx_o     (scan_idx),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .segments_o     (segments_o),
    .digit_enable_o (digit_enable_o),
    .digit_index_o  (digit_index_o)
  );

endmodule

@@ rtl/sstd_in_reg.sv @@
// input register for the seven-segment text display
// depends on sstd_pkg
module sstd_in_reg import sstd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] char_code_i,
  input  logic       start_of_text_i,
  input  logic       advance_i,
  output beat_t      beat_o
);

  logic       valid_q, valid_d;
  op_e        op_q;
  logic [7:0] char_q;
  logic       start_q;
  logic       accept;

  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      char_q  <= char_code_i;
      start_q <= start_of_text_i;
    end
  end

  assign beat_o = '{valid: valid_q, op: op_q, char_code: char_q, start_of_text: start_q};

endmodule

@@ rtl/sstd_store.sv @@
// digit store with write pointer and dot merging
// depends on sstd_pkg
module sstd_store import sstd_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [7:0]      char_code_i,
  input  logic            start_of_text_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0]      store_q [StoreDepth];
  logic [7:0]      store_d [StoreDepth];
  logic [PosW-1:0] wpos_q, wpos_d;
  logic            merge_q, merge_d;
  logic [PosW-1:0] wpos_base;
  logic            merge_base;
  logic [PosW-1:0] wpos_prev;

  always_comb begin
    wpos_base  = start_of_text_i ? '0 : wpos_q;
    merge_base = start_of_text_i ? 1'b0 : merge_q;
    wpos_prev  = wpos_base - PosW'(1);
    store_d    = store_q;
    wpos_d     = wpos_q;
    merge_d    = merge_q;
    if (wr_en_i) begin
      wpos_d = wpos_base;
      if (char_code_i == CharDot && merge_base) begin
        // dot lights the previous digit instead of taking a position
        store_d[wpos_prev[IdxW-1:0]] = store_q[wpos_prev[IdxW-1:0]] & DotClear;
        merge_d = 1'b0;
      end else if (wpos_base < PosW'(DIGIT_COUNT)) begin
        store_d[wpos_base[IdxW-1:0]] = font_of(char_code_i);
        wpos_d  = wpos_base + PosW'(1);
        merge_d = 1'b1;
      end else begin
        merge_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= SegBlank;
      end
      wpos_q  <= '0;
      merge_q <= 1'b0;
    end else begin
      store_q <= store_d;
      wpos_q  <= wpos_d;
      merge_q <= merge_d;
    end
  end

  assign rd_data_o = store_q[rd_idx_i];

endmodule

@@ rtl/sstd_scan.sv @@
// scan counter and result register
// depends on sstd_pkg
module sstd_scan import sstd_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            tick_i,
  output logic            ready_o,
  output logic [IdxW-1:0] scan_idx_o,
  input  logic [7:0]      rd_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      segments_o,
  output logic [7:0]      digit_enable_o,
  output logic [2:0]      digit_index_o
);

  logic [IdxW-1:0] scan_q, scan_d;
  logic            valid_q, valid_d;
  logic [7:0]      seg_q;
  logic [7:0]      en_q;
  logic [IdxW-1:0] idx_q;

  // result slot is free, or is emptied this cycle
  assign ready_o = !valid_q || out_ready_i;

  always_comb begin
    scan_d  = scan_q;
    valid_d = valid_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (tick_i) begin
      valid_d = 1'b1;
      scan_d  = (scan_q == IdxW'(DIGIT_COUNT - 1)) ? '0 : scan_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      scan_q  <= scan_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      seg_q <= rd_data_i;
      en_q  <= 8'(1) << scan_q;
      idx_q <= scan_q;
    end
  end

  assign scan_idx_o     = scan_q;
  assign out_valid_o    = valid_q;
  assign segments_o     = seg_q;
  assign digit_enable_o = en_q;
  assign digit_index_o  = idx_q;

endmodule
